@@ design/gfmi_pkg.sv @@
// Shared types, constants and field helpers for the GF(2^128) arithmetic unit.
`default_nettype none

package gfmi_pkg;

  // field element and transport widths
  localparam int DATA_W     = 64;
  localparam int ELEM_W     = 2 * DATA_W;
  localparam int FUNC_W     = 2;
  localparam int TERM_W     = 7;

  // multiplier: MSB-first, MUL_DIGIT bits of the second operand per cycle
  localparam int MUL_DIGIT  = 8;
  localparam int MUL_STEPS  = ELEM_W / MUL_DIGIT;
  localparam int STEP_W     = $clog2(MUL_STEPS);

  // inversion by square-and-multiply rounds
  localparam int INV_ROUNDS = 126;
  localparam int ROUND_W    = 7;

  // low part of x^128 + x^7 + x^2 + x + 1
  localparam logic [7:0] POLY_LOW = 8'h87;

  // function codes
  localparam logic [FUNC_W-1:0] FN_MUL = 2'd0;
  localparam logic [FUNC_W-1:0] FN_INV = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SUM = 2'd2;

  typedef logic [ELEM_W-1:0] elem_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN
  } state_t;

  // what the running multiply is for
  typedef enum logic [2:0] {
    OP_MUL,
    OP_SUM,
    OP_SUM_EMIT,
    OP_INV_SQ,
    OP_INV_PROD,
    OP_INV_FINAL
  } op_t;

  // operand sources for a multiply start (p, q)
  typedef enum logic [2:0] {
    SEL_IN_AB,
    SEL_IN_AA,
    SEL_IN_AX,
    SEL_PROD_RES,
    SEL_RES_RES,
    SEL_SQ_SQ
  } mul_sel_t;

  // where a finished product goes
  typedef enum logic [2:0] {
    DST_NONE,
    DST_SQ,
    DST_PROD,
    DST_SUM,
    DST_OUT_MUL,
    DST_OUT_SUM
  } dst_t;

  typedef struct packed {
    logic     start;
    mul_sel_t sel;
    logic     step;
    logic     prod_init;
    dst_t     dst;
  } dp_cmd_t;

  typedef struct packed {
    logic sum_full;
  } dp_stat_t;

  // multiply by x and reduce
  function automatic elem_t times_x(elem_t v);
    elem_t red;
    red = v[ELEM_W-1] ? elem_t'(POLY_LOW) : elem_t'(0);
    return {v[ELEM_W-2:0], 1'b0} ^ red;
  endfunction

endpackage

`default_nettype wire

@@ design/gfmi_in_if.sv @@
// Input channel: function code, two operands as 64-bit halves and last flag.
`default_nettype none

interface gfmi_in_if
  import gfmi_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [DATA_W-1:0] a_lo;
  logic [DATA_W-1:0] a_hi;
  logic [DATA_W-1:0] b_lo;
  logic [DATA_W-1:0] b_hi;
  logic              last;

  modport source (
    output valid, func, a_lo, a_hi, b_lo, b_hi, last,
    input  ready
  );

  modport sink (
    input  valid, func, a_lo, a_hi, b_lo, b_hi, last,
    output ready
  );
endinterface

`default_nettype wire

@@ design/gfmi_out_if.sv @@
// Result channel: one field element as 64-bit halves.
`default_nettype none

interface gfmi_out_if
  import gfmi_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] r_lo;
  logic [DATA_W-1:0] r_hi;

  modport source (
    output valid, r_lo, r_hi,
    input  ready
  );

  modport sink (
    input  valid, r_lo, r_hi,
    output ready
  );
endinterface

`default_nettype wire

@@ design/gfmi_dp.sv @@
// Datapath: digit-serial field multiplier, inversion registers, sum accumulator, result.
`default_nettype none

module gfmi_dp
  import gfmi_pkg::*;
#(
  parameter int SUM_TERMS = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [DATA_W-1:0] in_a_lo,
  input  wire logic [DATA_W-1:0] in_a_hi,
  input  wire logic [DATA_W-1:0] in_b_lo,
  input  wire logic [DATA_W-1:0] in_b_hi,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  output logic [ELEM_W-1:0]      res
);

  localparam logic [TERM_W:0] SUM_LIMIT = (TERM_W + 1)'(SUM_TERMS);

  elem_t              mul_p_r;
  elem_t              mul_q_r;
  elem_t              mul_acc_r;
  elem_t              sq_r;
  elem_t              prod_r;
  elem_t              sum_acc_r;
  elem_t              res_r;
  logic [TERM_W-1:0]  term_idx_r;

  elem_t              in_a;
  elem_t              in_b;
  elem_t              x_pow;
  elem_t              src_p;
  elem_t              src_q;
  elem_t              acc_step;

  assign in_a  = {in_a_hi, in_a_lo};
  assign in_b  = {in_b_hi, in_b_lo};
  assign x_pow = elem_t'(1) << term_idx_r;

  // flag the element that closes a full sum
  assign stat.sum_full = ({1'b0, term_idx_r} + (TERM_W + 1)'(1)) >= SUM_LIMIT;

  assign res = res_r;

  // pick multiplier operands
  always_comb begin
    case (cmd.sel)
      SEL_IN_AB: begin
        src_p = in_a;
        src_q = in_b;
      end
      SEL_IN_AA: begin
        src_p = in_a;
        src_q = in_a;
      end
      SEL_IN_AX: begin
        src_p = in_a;
        src_q = x_pow;
      end
      SEL_PROD_RES: begin
        src_p = prod_r;
        src_q = mul_acc_r;
      end
      SEL_RES_RES: begin
        src_p = mul_acc_r;
        src_q = mul_acc_r;
      end
      SEL_SQ_SQ: begin
        src_p = sq_r;
        src_q = sq_r;
      end
      default: begin
        src_p = in_a;
        src_q = in_b;
      end
    endcase
  end

  // one digit of Horner multiply, top bits of q first
  always_comb begin
    acc_step = mul_acc_r;
    for (int k = 0; k < MUL_DIGIT; k++) begin
      acc_step = times_x(acc_step) ^ (mul_q_r[ELEM_W-1-k] ? mul_p_r : elem_t'(0));
    end
  end

  // advance the multiplier and capture finished products
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mul_p_r   <= src_p;
      mul_q_r   <= src_q;
      mul_acc_r <= elem_t'(0);
    end else if (cmd.step) begin
      mul_acc_r <= acc_step;
      mul_q_r   <= mul_q_r << MUL_DIGIT;
    end
    if (cmd.prod_init) begin
      prod_r <= in_a;
    end
    case (cmd.dst)
      DST_SQ:      sq_r   <= mul_acc_r;
      DST_PROD:    prod_r <= mul_acc_r;
      DST_OUT_MUL: res_r  <= mul_acc_r;
      DST_OUT_SUM: res_r  <= sum_acc_r ^ mul_acc_r;
      default: ;
    endcase
  end

  // hold the running sum and its term index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_acc_r  <= elem_t'(0);
      term_idx_r <= '0;
    end else begin
      case (cmd.dst)
        DST_SUM: begin
          sum_acc_r  <= sum_acc_r ^ mul_acc_r;
          term_idx_r <= term_idx_r + TERM_W'(1);
        end
        DST_OUT_SUM: begin
          sum_acc_r  <= elem_t'(0);
          term_idx_r <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/gfmi_ctrl.sv @@
// Controller: sequences multiplies for each function and owns the result handshake.
`default_nettype none

module gfmi_ctrl
  import gfmi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire logic              in_last,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dp_cmd_t                cmd,
  input  wire dp_stat_t          stat
);

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               slot_free;
  logic               out_set;

  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_MUL;
      cnt_r       <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    round_nxt     = round_r;
    in_ready      = 1'b0;
    out_set       = 1'b0;
    cmd.start     = 1'b0;
    cmd.sel       = SEL_IN_AB;
    cmd.step      = 1'b0;
    cmd.prod_init = 1'b0;
    cmd.dst       = DST_NONE;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_func)
            FN_MUL: begin
              cmd.start = 1'b1;
              cmd.sel   = SEL_IN_AB;
              op_nxt    = OP_MUL;
              state_nxt = ST_MUL;
            end
            FN_INV: begin
              cmd.start     = 1'b1;
              cmd.sel       = SEL_IN_AA;
              cmd.prod_init = 1'b1;
              round_nxt     = '0;
              op_nxt        = OP_INV_SQ;
              state_nxt     = ST_MUL;
            end
            FN_SUM: begin
              cmd.start = 1'b1;
              cmd.sel   = SEL_IN_AX;
              op_nxt    = (in_last || stat.sum_full) ? OP_SUM_EMIT : OP_SUM;
              state_nxt = ST_MUL;
            end
            default: ;
          endcase
        end
      end

      ST_MUL: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        case (op_r)
          OP_MUL, OP_INV_FINAL: begin
            if (slot_free) begin
              cmd.dst   = DST_OUT_MUL;
              out_set   = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          OP_SUM_EMIT: begin
            if (slot_free) begin
              cmd.dst   = DST_OUT_SUM;
              out_set   = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          OP_SUM: begin
            cmd.dst   = DST_SUM;
            state_nxt = ST_IDLE;
          end
          OP_INV_SQ: begin
            cmd.dst   = DST_SQ;
            cmd.start = 1'b1;
            cmd.sel   = SEL_PROD_RES;
            op_nxt    = OP_INV_PROD;
            state_nxt = ST_MUL;
          end
          OP_INV_PROD: begin
            cmd.dst   = DST_PROD;
            cmd.start = 1'b1;
            state_nxt = ST_MUL;
            if (round_r == ROUND_W'(INV_ROUNDS - 1)) begin
              cmd.sel = SEL_RES_RES;
              op_nxt  = OP_INV_FINAL;
            end else begin
              cmd.sel   = SEL_SQ_SQ;
              round_nxt = round_r + ROUND_W'(1);
              op_nxt    = OP_INV_SQ;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end

      default: state_nxt = ST_IDLE;
    endcase

    // result beat: set on capture, drop once taken
    if (out_set) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // step counter rests at zero outside a multiply
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_MUL) |-> (cnt_r == '0))
    else $error("step counter not cleared outside multiply");

  // last digit always hands over to the finish cycle
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && cnt_r == STEP_W'(MUL_STEPS - 1)) |=> (state_r == ST_FIN))
    else $error("multiply did not finish after last digit");

  // final inversion squaring only after all rounds
  a_inv_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (op_r == OP_INV_FINAL) |-> (round_r == ROUND_W'(INV_ROUNDS - 1)))
    else $error("inversion finished early");

  // a pending result blocks the finish cycle from overwriting it
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ready &&
     (op_r == OP_MUL || op_r == OP_INV_FINAL || op_r == OP_SUM_EMIT))
    |=> (state_r == ST_FIN && out_valid_r))
    else $error("result overwritten while waiting");

endmodule

`default_nettype wire

@@ design/gf2_128_multiply_invert_sum_top.sv @@
// Top level of the GF(2^128) multiply, invert and polynomial-sum unit.
//
// Usage: items arrive on in_beat (valid/ready), each with a function code:
// multiply a*b, invert a, or add a*x^i into a running sum. Results leave on
// out_beat (valid/ready) as two 64-bit halves; multiply and invert always
// give one beat, a sum element gives one only when it carries last or is
// element SUM_TERMS of the sum. Unused code 3 is taken and dropped.
// One item is in work at a time; in_beat.ready is high while the unit idles.
// A multiply is a 128-bit carry-less product reduced by x^128+x^7+x^2+x+1,
// done 8 bits of b per cycle by one shared multiplier: the step cycles, then
// the finish cycle that registers the result; the next item is taken only
// once the unit is back in idle.
// Invert is 253 such products chained (square and multiply rounds).
// The unit returns to idle after the finish cycle of an item's last product.
// Reset (rst_n low, synchronous) clears the sum and its term index, the
// sequencer and the result valid. A result waits in its register until
// taken; the unit still takes the next item meanwhile, but holds in its
// finish cycle if a second result is ready before the first one is taken.
`default_nettype none

module gf2_128_multiply_invert_sum_top
  import gfmi_pkg::*;
#(
  parameter int SUM_TERMS = 128
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gfmi_in_if.sink     in_beat,
  gfmi_out_if.source  out_beat
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [ELEM_W-1:0] res;
  logic              in_ready;
  logic              out_valid;

  gfmi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_beat.valid),
    .in_func   (in_beat.func),
    .in_last   (in_beat.last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_beat.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  gfmi_dp #(
    .SUM_TERMS (SUM_TERMS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_a_lo (in_beat.a_lo),
    .in_a_hi (in_beat.a_hi),
    .in_b_lo (in_beat.b_lo),
    .in_b_hi (in_beat.b_hi),
    .cmd     (cmd),
    .stat    (stat),
    .res     (res)
  );

  // drive channel handshakes and result halves
  assign in_beat.ready  = in_ready;
  assign out_beat.valid = out_valid;
  assign out_beat.r_lo  = res[DATA_W-1:0];
  assign out_beat.r_hi  = res[ELEM_W-1:DATA_W];

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the GF(2^128) multiply, invert and polynomial-sum unit.
`default_nettype none

module testbench;
  import gfmi_pkg::*;

  typedef logic [FUNC_W-1:0] func_code_t;

  // function code that the unit takes and drops
  localparam func_code_t FN_UNUSED = 2'd3;
  localparam int         SUM_LEN   = 128;
  localparam int         DRAIN_CYC = 40;
  localparam int         LIMIT_CYC = 3_000_000;

  logic clk;
  logic rst_n;
  logic idle_on;
  logic error_seen;

  gfmi_in_if  in_ch ();
  gfmi_out_if out_ch ();

  // predictor state: running sum, its term index, results still to arrive
  elem_t sum_acc;
  int    term_count;
  elem_t field_results_due[$];

  gf2_128_multiply_invert_sum_top #(
    .SUM_TERMS (SUM_LEN)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_ch.sink),
    .out_beat (out_ch.source)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    repeat (LIMIT_CYC) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // multiply by x, fold x^128 back as x^7 + x^2 + x + 1
  function automatic elem_t shift_reduce(elem_t v);
    elem_t folded;
    folded = v[ELEM_W-1] ? elem_t'(8'h87) : elem_t'(0);
    return {v[ELEM_W-2:0], 1'b0} ^ folded;
  endfunction

  function automatic elem_t field_product(elem_t p, elem_t q);
    elem_t acc;
    acc = '0;
    for (int k = 0; k < ELEM_W; k++) begin
      if (q[k]) acc ^= p;
      p = shift_reduce(p);
    end
    return acc;
  endfunction

  // a^(2^128-2): square-and-multiply chain, zero stays zero
  function automatic elem_t field_inverse(elem_t v);
    elem_t prod;
    elem_t sq;
    prod = v;
    sq   = v;
    for (int k = 0; k < ELEM_W - 2; k++) begin
      sq   = field_product(sq, sq);
      prod = field_product(prod, sq);
    end
    return field_product(prod, prod);
  endfunction

  // work out the result (if any) of one accepted beat
  function automatic void predict_field_op(func_code_t fn, elem_t a, elem_t b, logic last);
    elem_t term;
    case (fn)
      FN_MUL: field_results_due.push_back(field_product(a, b));
      FN_INV: field_results_due.push_back(field_inverse(a));
      FN_SUM: begin
        term = a;
        for (int k = 0; k < term_count; k++) term = shift_reduce(term);
        sum_acc ^= term;
        if (!last && term_count + 1 < SUM_LEN) begin
          term_count++;
        end else begin
          field_results_due.push_back(sum_acc);
          sum_acc    = '0;
          term_count = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return elem_t'(1);
      2: return '1;
      3: return elem_t'(1) << $urandom_range(0, ELEM_W - 1);
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  // drive one beat, hold until taken, then predict
  task automatic send_item(func_code_t fn, elem_t a, elem_t b, logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= fn;
    in_ch.a_lo  <= a[DATA_W-1:0];
    in_ch.a_hi  <= a[ELEM_W-1:DATA_W];
    in_ch.b_lo  <= b[DATA_W-1:0];
    in_ch.b_hi  <= b[ELEM_W-1:DATA_W];
    in_ch.last  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_field_op(fn, a, b, last);
  endtask

  // result side: random stall bursts, compare each beat with the oldest prediction
  initial begin
    int    stall_left;
    elem_t want;
    stall_left   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (field_results_due.size() == 0) begin
          $display("%0t unexpected result: r_hi %h r_lo %h", $time,
                   out_ch.r_hi, out_ch.r_lo);
          error_seen = 1'b1;
        end else begin
          want = field_results_due.pop_front();
          if (out_ch.r_lo !== want[DATA_W-1:0]) begin
            $display("%0t r_lo mismatch: expected %h, actual %h", $time,
                     want[DATA_W-1:0], out_ch.r_lo);
            error_seen = 1'b1;
          end
          if (out_ch.r_hi !== want[ELEM_W-1:DATA_W]) begin
            $display("%0t r_hi mismatch: expected %h, actual %h", $time,
                     want[ELEM_W-1:DATA_W], out_ch.r_hi);
            error_seen = 1'b1;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // extremes of both operands, reduction carry, ignored last flag
  task automatic test_multiply_corners();
    send_item(FN_MUL, '0, '1, 1'b1);
    send_item(FN_MUL, '1, '1, 1'b0);
    send_item(FN_MUL, elem_t'(1), rand_elem(), 1'b1);
    send_item(FN_MUL, elem_t'(1) << 127, elem_t'(2), 1'b0);
    send_item(FN_MUL, elem_t'(1) << 127, elem_t'(1) << 127, 1'b1);
    send_item(FN_MUL, {$urandom, $urandom, $urandom, $urandom},
              {$urandom, $urandom, $urandom, $urandom}, 1'b0);
  endtask

  // zero maps to zero, one to one, plus all-ones and x
  task automatic test_invert_corners();
    send_item(FN_INV, '0, '1, 1'b1);
    send_item(FN_INV, elem_t'(1), '0, 1'b0);
    send_item(FN_INV, '1, '1, 1'b0);
    send_item(FN_INV, elem_t'(2), '0, 1'b1);
  endtask

  // short sums, with multiply, invert and dropped codes in the middle
  task automatic test_sum_basics();
    send_item(FN_SUM, '1, '0, 1'b1);
    send_item(FN_SUM, elem_t'(1) << 127, '1, 1'b0);
    send_item(FN_SUM, '1, '0, 1'b0);
    send_item(FN_SUM, rand_elem(), '1, 1'b1);
    send_item(FN_SUM, elem_t'(1) << 127, '0, 1'b0);
    send_item(FN_MUL, '1, elem_t'(1) << 127, 1'b1);
    send_item(FN_UNUSED, '1, '1, 1'b1);
    send_item(FN_INV, {$urandom, $urandom, $urandom, $urandom}, '1, 1'b1);
    send_item(FN_SUM, '1, '1, 1'b1);
    send_item(FN_UNUSED, '0, '0, 1'b0);
    send_item(FN_SUM, '1, '1, 1'b0);
    send_item(FN_SUM, elem_t'(1), '0, 1'b1);
  endtask

  // full-length sums: emit on the last term with and without the flag
  task automatic test_sum_wraparound();
    for (int i = 0; i < SUM_LEN; i++) begin
      if (i == SUM_LEN / 2) send_item(FN_MUL, rand_elem(), rand_elem(), 1'b1);
      send_item(FN_SUM, rand_elem(), '0, 1'b0);
    end
    for (int i = 0; i < SUM_LEN; i++) begin
      send_item(FN_SUM, (i == SUM_LEN - 1) ? elem_t'('1) : rand_elem(), '0,
                (i == SUM_LEN - 1));
    end
    send_item(FN_SUM, elem_t'(1) << 127, '0, 1'b0);
    send_item(FN_SUM, '1, '0, 1'b1);
  endtask

  // mostly multiplies and well-formed sums, some inverts, dropped codes, open sums
  task automatic test_random_mix(int n_items, logic allow_idle);
    int   sent;
    int   pick;
    int   run_len;
    logic run_closed;
    sent    = 0;
    idle_on = allow_idle;
    while (sent < n_items) begin
      if (allow_idle && $urandom_range(0, 63) == 0) idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_item(FN_MUL, rand_elem(), rand_elem(), 1'($urandom));
        sent++;
      end else if (pick < 49) begin
        send_item(FN_INV, rand_elem(), rand_elem(), 1'($urandom));
        sent++;
      end else if (pick < 53) begin
        send_item(FN_UNUSED, rand_elem(), rand_elem(), 1'($urandom));
      end else begin
        run_len    = $urandom_range(1, 10);
        run_closed = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < run_len; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 12) send_item(FN_MUL, rand_elem(), rand_elem(), 1'($urandom));
          else if (pick < 16) send_item(FN_UNUSED, rand_elem(), rand_elem(), 1'($urandom));
          send_item(FN_SUM, rand_elem(), rand_elem(), run_closed && (i == run_len - 1));
          sent++;
        end
      end
    end
  endtask

  initial begin
    error_seen  = 1'b0;
    idle_on     = 1'b1;
    sum_acc     = '0;
    term_count  = 0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func  <= FN_MUL;
    in_ch.a_lo  <= '0;
    in_ch.a_hi  <= '0;
    in_ch.b_lo  <= '0;
    in_ch.b_hi  <= '0;
    in_ch.last  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_multiply_corners();
    test_invert_corners();
    test_sum_basics();
    test_sum_wraparound();
    test_random_mix(880, 1'b1);
    // close any open sum, then run the tail with no idling
    send_item(FN_SUM, rand_elem(), '0, 1'b1);
    test_random_mix(130, 1'b0);
    send_item(FN_SUM, rand_elem(), '0, 1'b1);

    // drain
    in_ch.valid <= 1'b0;
    while (field_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (!error_seen) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
